### rtl/u16pbo_pkg.sv
// Shared constants for the UTF-16 position to byte offset block.
// No dependencies; imported by utf16_position_to_byte_offset.
package u16pbo_pkg;

  // Default widths for the top level parameters
  localparam int OFFSET_WIDTH_DEF   = 24;
  localparam int POSITION_WIDTH_DEF = 20;

  // Byte classes of UTF-8
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [7:0] MASK_TWO    = 8'hE0;
  localparam logic [7:0] LEAD_TWO    = 8'hC0;
  localparam logic [7:0] MASK_THREE  = 8'hF0;
  localparam logic [7:0] LEAD_THREE  = 8'hE0;
  localparam logic [7:0] MASK_FOUR   = 8'hF8;
  localparam logic [7:0] LEAD_FOUR   = 8'hF0;
  localparam logic [5:0] CONT_BITS_SUPP = 6'h10;  // continuation bits that push past 0xFFFF

endpackage

### rtl/utf16_position_to_byte_offset.sv
// UTF-16 line/column to UTF-8 byte offset over a streamed text.
// The result word is formed from the closing word in the input register and held in the result register.
// Throughput: one input word per cycle; a closing word waits in the input register only
// while the result register still holds an answer that out_ready has not taken.
// Reset (rst_n low, synchronous) empties both registers and leaves no query open.
// Depends on u16pbo_pkg.
module utf16_position_to_byte_offset #(
  parameter int OFFSET_WIDTH   = u16pbo_pkg::OFFSET_WIDTH_DEF,
  parameter int POSITION_WIDTH = u16pbo_pkg::POSITION_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_text_byte,
  input  logic                      in_byte_present,
  input  logic                      in_first_item,
  input  logic                      in_last_item,
  input  logic [POSITION_WIDTH-1:0] in_query_line,
  input  logic [POSITION_WIDTH-1:0] in_query_column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OFFSET_WIDTH-1:0]   out_byte_offset,
  output logic                      out_found
);
  import u16pbo_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int CW = OFFSET_WIDTH + 1;   // counters saturate at 2^OFFSET_WIDTH
  localparam int SW = OFFSET_WIDTH + 2;   // line start plus counted bytes
  localparam logic [CW-1:0] OFFSET_OVER = {1'b1, {OFFSET_WIDTH{1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEEK, PH_WALK, PH_PEND, PH_CHECK, PH_OK, PH_BAD
  } phase_t;

  typedef struct packed {
    phase_t        ph;
    logic [PW-1:0] cl;
    logic [1:0]    skip;
    logic          take;
  } char_res_t;

  // Saturating add of a small count to a position counter
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [2:0] n);
    logic [SW-1:0] sum;
    sum = SW'(v) + SW'(n);
    sat_add = (sum > SW'(OFFSET_OVER)) ? OFFSET_OVER : sum[CW-1:0];
  endfunction

  // Account one whole character against the remaining columns
  function automatic char_res_t take_char(input logic [2:0] len, input logic [1:0] units,
                                          input logic [PW-1:0] cl, input logic [1:0] skip);
    char_res_t r;
    r.cl   = cl;
    r.skip = skip;
    r.take = 1'b0;
    r.ph   = PH_OK;
    if (cl >= PW'(units)) begin
      r.take = 1'b1;
      r.cl   = cl - PW'(units);
      r.skip = 2'(len - 3'd1);
      if (r.cl == '0) begin
        r.ph = (r.skip != 2'd0) ? PH_CHECK : PH_OK;
      end else begin
        r.ph = PH_WALK;
      end
    end
    take_char = r;
  endfunction

  // Phase after a continuation byte (skip already decremented)
  function automatic phase_t cont_phase(input phase_t ph, input logic [1:0] skip,
                                        input logic is_nl);
    phase_t p;
    p = ph;
    if (is_nl) begin
      p = (skip == 2'd0 && ph == PH_CHECK) ? PH_OK : PH_BAD;
    end else if (skip == 2'd0 && ph == PH_CHECK) begin
      p = PH_OK;
    end
    cont_phase = p;
  endfunction

  // Input register
  logic          st_valid_r;
  logic [7:0]    st_byte_r;
  logic          st_present_r, st_first_r, st_last_r;
  logic [PW-1:0] st_line_r, st_col_r;
  logic          st_adv;

  // Walk state
  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] newlines_left_r, newlines_left_nxt;
  logic [PW-1:0] columns_left_r, columns_left_nxt;
  logic [CW-1:0] line_start_r, line_start_nxt;
  logic [CW-1:0] byte_position_r, byte_position_nxt;
  logic [CW-1:0] counted_bytes_r, counted_bytes_nxt;
  logic [1:0]    skip_left_r, skip_left_nxt;
  logic [7:0]    pending_lead_r, pending_lead_nxt;

  // Result register
  logic                    out_valid_r;
  logic [OFFSET_WIDTH-1:0] out_byte_offset_r;
  logic                    out_found_r;

  logic                    has_result;
  logic                    res_ok;
  logic [SW-1:0]           res_sum;
  logic [OFFSET_WIDTH-1:0] res_offset;

  // Per-byte walk update
  always_comb begin
    logic [2:0] len;
    logic [1:0] units;
    logic       is_nl;
    char_res_t  tc;
    phase_nxt         = phase_r;
    newlines_left_nxt = newlines_left_r;
    columns_left_nxt  = columns_left_r;
    line_start_nxt    = line_start_r;
    byte_position_nxt = byte_position_r;
    counted_bytes_nxt = counted_bytes_r;
    skip_left_nxt     = skip_left_r;
    pending_lead_nxt  = pending_lead_r;
    has_result        = 1'b0;
    res_ok            = 1'b0;
    res_sum           = '0;
    res_offset        = '0;
    len               = 3'd1;
    units             = 2'd1;
    is_nl             = (st_byte_r == NEWLINE);
    tc                = '0;

    // a first word opens a fresh query
    if (st_first_r) begin
      newlines_left_nxt = st_line_r;
      columns_left_nxt  = st_col_r;
      line_start_nxt    = '0;
      byte_position_nxt = '0;
      counted_bytes_nxt = '0;
      skip_left_nxt     = 2'd0;
      pending_lead_nxt  = 8'h00;
      phase_nxt         = (st_line_r == '0) ? PH_WALK : PH_SEEK;
    end

    if (phase_nxt != PH_IDLE) begin
      if (st_present_r) begin
        byte_position_nxt = sat_add(byte_position_nxt, 3'd1);
        unique case (phase_nxt)
          PH_SEEK: begin
            if (is_nl) begin
              newlines_left_nxt = newlines_left_nxt - PW'(1);
              if (newlines_left_nxt == '0) begin
                line_start_nxt = byte_position_nxt;
                skip_left_nxt  = 2'd0;
                phase_nxt      = PH_WALK;
              end
            end
          end
          PH_WALK, PH_CHECK: begin
            if (skip_left_nxt != 2'd0 || phase_nxt == PH_CHECK) begin
              skip_left_nxt = skip_left_nxt - 2'd1;
              phase_nxt     = cont_phase(phase_nxt, skip_left_nxt, is_nl);
            end else if ((st_byte_r & MASK_FOUR) == LEAD_FOUR) begin
              pending_lead_nxt = st_byte_r;
              phase_nxt        = PH_PEND;
            end else begin
              if ((st_byte_r & MASK_TWO) == LEAD_TWO) begin
                len = 3'd2;
              end else if ((st_byte_r & MASK_THREE) == LEAD_THREE) begin
                len = 3'd3;
              end
              tc = take_char(len, 2'd1, columns_left_nxt, skip_left_nxt);
              phase_nxt        = tc.ph;
              columns_left_nxt = tc.cl;
              skip_left_nxt    = tc.skip;
              if (tc.take) begin
                counted_bytes_nxt = sat_add(counted_bytes_nxt, len);
              end
              if (phase_nxt == PH_WALK && is_nl) begin
                phase_nxt = PH_BAD;
              end
            end
          end
          PH_PEND: begin
            // four-byte lead: next byte decides whether it needs a surrogate pair
            units = (pending_lead_nxt[2:0] != 3'd0 || st_byte_r[5:0] >= CONT_BITS_SUPP)
                    ? 2'd2 : 2'd1;
            tc = take_char(3'd4, units, columns_left_nxt, skip_left_nxt);
            phase_nxt        = tc.ph;
            columns_left_nxt = tc.cl;
            skip_left_nxt    = tc.skip;
            if (tc.take) begin
              counted_bytes_nxt = sat_add(counted_bytes_nxt, 3'd4);
            end
            if (phase_nxt == PH_WALK || phase_nxt == PH_CHECK) begin
              skip_left_nxt = skip_left_nxt - 2'd1;
              phase_nxt     = cont_phase(phase_nxt, skip_left_nxt, is_nl);
            end
          end
          default: ;
        endcase
      end

      // closing word: judge the walk and form the offset
      if (st_last_r) begin
        has_result = 1'b1;
        unique case (phase_nxt)
          PH_WALK: res_ok = (skip_left_nxt == 2'd0) && (byte_position_nxt == line_start_nxt);
          PH_PEND: res_ok = columns_left_nxt <
                            ((pending_lead_nxt[2:0] != 3'd0) ? PW'(2) : PW'(1));
          PH_OK:   res_ok = 1'b1;
          default: res_ok = 1'b0;
        endcase
        res_sum = SW'(line_start_nxt) + SW'(counted_bytes_nxt);
        if (res_sum[SW-1:OFFSET_WIDTH] != '0) begin
          res_ok = 1'b0;
        end
        res_offset = res_ok ? res_sum[OFFSET_WIDTH-1:0] : '0;
        phase_nxt  = PH_IDLE;
      end
    end
  end

  // The input register moves on unless its result has nowhere to go
  assign st_adv   = st_valid_r && (!has_result || !out_valid_r || out_ready);
  assign in_ready = !st_valid_r || st_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      st_byte_r    <= in_text_byte;
      st_present_r <= in_byte_present;
      st_first_r   <= in_first_item;
      st_last_r    <= in_last_item;
      st_line_r    <= in_query_line;
      st_col_r     <= in_query_column;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      newlines_left_r <= '0;
      columns_left_r  <= '0;
      line_start_r    <= '0;
      byte_position_r <= '0;
      counted_bytes_r <= '0;
      skip_left_r     <= 2'd0;
      pending_lead_r  <= 8'h00;
    end else if (st_adv) begin
      phase_r         <= phase_nxt;
      newlines_left_r <= newlines_left_nxt;
      columns_left_r  <= columns_left_nxt;
      line_start_r    <= line_start_nxt;
      byte_position_r <= byte_position_nxt;
      counted_bytes_r <= counted_bytes_nxt;
      skip_left_r     <= skip_left_nxt;
      pending_lead_r  <= pending_lead_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (st_adv && has_result) begin
      out_byte_offset_r <= res_offset;
      out_found_r       <= res_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_found       = out_found_r;

  // Checks
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r || out_byte_offset_r == '0))
    else $error("not-found result carries a non-zero offset");

  a_line_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    line_start_r <= byte_position_r)
    else $error("line start beyond current byte position");

  a_seek_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEEK |-> newlines_left_r != '0)
    else $error("seeking with no newlines left to skip");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_valid_r && st_last_r))
    else $error("result produced without a closing word");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf16_position_to_byte_offset: streams UTF-8 texts with
// line/column queries and checks each offset against a tracker class. Needs u16pbo_pkg.

module testbench;
  import u16pbo_pkg::*;

  localparam int OW = OFFSET_WIDTH_DEF;
  localparam int PW = POSITION_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1400;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [7:0] text_bytes_t[$];

  // where the walk over the text currently stands
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_LINES, SCAN_UNITS, SCAN_SURROGATE, SCAN_TAIL, SCAN_DONE, SCAN_BROKEN
  } scan_t;

  typedef struct packed {
    logic [OW-1:0] byte_offset;
    logic          found;
  } answer_t;

  // Tracks the query in flight and holds the answers still owed by the block
  class position_tracker;
    localparam logic [OW+1:0] CAP = (OW+2)'(1) << OW;

    scan_t         scan = SCAN_IDLE;
    logic [PW-1:0] lines_to_skip = '0;
    logic [PW-1:0] units_left = '0;
    logic [OW:0]   line_base = '0;
    logic [OW:0]   byte_count = '0;
    logic [OW:0]   char_bytes = '0;
    logic [1:0]    tail_left = '0;
    logic [7:0]    wide_lead = '0;
    answer_t       offset_answers[$];
    int            errors = 0;

    // counters stick at 2^OW so an overlong text cannot wrap
    function logic [OW:0] sat_inc(logic [OW:0] v, int unsigned n);
      logic [OW+1:0] s;
      s = (OW+2)'(v) + (OW+2)'(n);
      if (s > CAP) s = CAP;
      return s[OW:0];
    endfunction

    function void count_char(int len, int units);
      if (units_left < units) begin
        scan = SCAN_DONE;  // column falls inside this character
        return;
      end
      char_bytes = sat_inc(char_bytes, len);
      units_left = units_left - PW'(units);
      tail_left = 2'(len - 1);
      if (units_left != 0) scan = SCAN_UNITS;
      else if (tail_left != 0) scan = SCAN_TAIL;
      else scan = SCAN_DONE;
    endfunction

    // trailing byte of a multi-byte character; a newline here cuts it short
    function void take_tail(logic [7:0] b);
      tail_left--;
      if (b == NEWLINE) begin
        if (tail_left == 0 && scan == SCAN_TAIL) scan = SCAN_DONE;
        else scan = SCAN_BROKEN;
      end else if (tail_left == 0 && scan == SCAN_TAIL) begin
        scan = SCAN_DONE;
      end
    endfunction

    function void take_lead(logic [7:0] b);
      int len;
      if ((b & MASK_FOUR) == LEAD_FOUR) begin
        wide_lead = b;
        scan = SCAN_SURROGATE;
        return;
      end
      if ((b & MASK_TWO) == LEAD_TWO) len = 2;
      else if ((b & MASK_THREE) == LEAD_THREE) len = 3;
      else len = 1;
      count_char(len, 1);
      if (scan == SCAN_UNITS && b == NEWLINE) scan = SCAN_BROKEN;
    endfunction

    function void take_byte(logic [7:0] b);
      int units;
      byte_count = sat_inc(byte_count, 1);
      case (scan)
        SCAN_LINES: begin
          if (b == NEWLINE) begin
            lines_to_skip--;
            if (lines_to_skip == 0) begin
              line_base = byte_count;
              tail_left = '0;
              scan = SCAN_UNITS;
            end
          end
        end
        SCAN_UNITS: begin
          if (tail_left != 0) take_tail(b);
          else take_lead(b);
        end
        SCAN_TAIL: take_tail(b);
        SCAN_SURROGATE: begin
          // the second byte decides whether the code point lies above 0xFFFF
          units = (wide_lead[2:0] != 0 || b[5:0] >= CONT_BITS_SUPP) ? 2 : 1;
          count_char(4, units);
          if (scan == SCAN_UNITS || scan == SCAN_TAIL) take_tail(b);
        end
        default: ;
      endcase
    endfunction

    // note one accepted input word; a closing word owes one answer
    function void take_word(logic [7:0] b, logic present, logic first, logic last,
                            logic [PW-1:0] qline, logic [PW-1:0] qcol);
      answer_t       a;
      logic          ok;
      logic [OW+1:0] sum;
      if (first) begin
        lines_to_skip = qline;
        units_left = qcol;
        line_base = '0;
        byte_count = '0;
        char_bytes = '0;
        tail_left = '0;
        wide_lead = '0;
        scan = (qline == 0) ? SCAN_UNITS : SCAN_LINES;
      end
      if (scan == SCAN_IDLE) return;
      if (present) take_byte(b);
      if (!last) return;
      case (scan)
        SCAN_UNITS:     ok = (tail_left == 0 && byte_count == line_base);
        SCAN_SURROGATE: ok = units_left < ((wide_lead[2:0] != 0) ? 2 : 1);
        SCAN_DONE:      ok = 1'b1;
        default:        ok = 1'b0;
      endcase
      sum = line_base + char_bytes;
      if (sum >= CAP) ok = 1'b0;
      a.found = ok;
      a.byte_offset = ok ? sum[OW-1:0] : '0;
      offset_answers.push_back(a);
      scan = SCAN_IDLE;
    endfunction

    function void check_answer(logic [OW-1:0] offset, logic found);
      answer_t want;
      if (offset_answers.size() == 0) begin
        $display("%0t: result with none owed, offset %0d found %0b", $time, offset, found);
        errors++;
        return;
      end
      want = offset_answers.pop_front();
      if (found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        errors++;
      end
      if (offset !== want.byte_offset) begin
        $display("%0t: byte_offset expected %0d actual %0d", $time, want.byte_offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    in_text_byte = '0;
  logic          in_byte_present = 1'b0;
  logic          in_first_item = 1'b0;
  logic          in_last_item = 1'b0;
  logic [PW-1:0] in_query_line = '0;
  logic [PW-1:0] in_query_column = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [OW-1:0] out_byte_offset;
  logic          out_found;

  position_tracker tracker;
  int              send_idle_pct = 14;
  int              recv_stall_pct = 67;
  int              stream_words = 0;
  int unsigned     cycles = 0;

  utf16_position_to_byte_offset i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_byte_present (in_byte_present),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .in_query_line   (in_query_line),
    .in_query_column (in_query_column),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_offset (out_byte_offset),
    .out_found       (out_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog plus both handshakes, sampled at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("utf16_position_to_byte_offset: mismatch");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) tracker.check_answer(out_byte_offset, out_found);
      if (in_valid && in_ready)
        tracker.take_word(in_text_byte, in_byte_present, in_first_item, in_last_item,
                          in_query_line, in_query_column);
    end
  end

  // present one word from a falling edge and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic present, input logic first,
                           input logic last, input logic [PW-1:0] qline,
                           input logic [PW-1:0] qcol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = b;
    in_byte_present = present;
    in_first_item = first;
    in_last_item = last;
    in_query_line = qline;
    in_query_column = qcol;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // one whole query; holes adds words without a byte, and an empty text is one such word
  task automatic send_text(input logic [PW-1:0] qline, input logic [PW-1:0] qcol,
                           input text_bytes_t text, input bit holes);
    text_bytes_t stream;
    bit          real_byte[$];
    foreach (text[i]) begin
      if (holes && $urandom_range(15) == 0) begin
        stream.push_back(8'($urandom));
        real_byte.push_back(1'b0);
      end
      stream.push_back(text[i]);
      real_byte.push_back(1'b1);
    end
    if (stream.size() == 0 || (holes && $urandom_range(15) == 0)) begin
      stream.push_back(8'($urandom));
      real_byte.push_back(1'b0);
    end
    foreach (stream[i])
      send_word(stream[i], real_byte[i], i == 0, i == stream.size() - 1,
                (i == 0) ? qline : PW'($urandom), (i == 0) ? qcol : PW'($urandom));
    stream_words += stream.size();
  endtask

  // hold the sender off until every owed answer is back
  task automatic drain_answers();
    in_valid = 1'b0;
    while (tracker.offset_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] tail_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // one character, mostly well formed, sometimes stray, invalid or cut short
  function automatic text_bytes_t one_char();
    text_bytes_t c;
    int          pick;
    int          len;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 40) begin
      b = 8'($urandom_range(127));
      if (b == NEWLINE) b = 8'h20;
      c.push_back(b);
    end else if (pick < 85) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       c.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3:       c.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: c.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (len - 1) c.push_back(tail_byte());
    end else if (pick < 90) begin
      c.push_back(tail_byte());
    end else if (pick < 93) begin
      c.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      len = $urandom_range(2, 4);
      case (len)
        2:       c.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3:       c.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: c.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat ($urandom_range(0, len - 2)) c.push_back(tail_byte());
    end
    return c;
  endfunction

  function automatic text_bytes_t make_text(output int breaks);
    text_bytes_t t;
    int          rows;
    rows = $urandom_range(1, 4);
    breaks = 0;
    for (int r = 0; r < rows; r++) begin
      repeat ($urandom_range(0, 6)) t = {t, one_char()};
      if (r < rows - 1 || $urandom_range(1) == 1) begin
        t.push_back(NEWLINE);
        breaks++;
      end
    end
    return t;
  endfunction

  // random queries up to a word count, with stray words and abandoned queries mixed in
  task automatic random_queries(input int goal);
    text_bytes_t   text;
    int            breaks;
    int            pick;
    logic [PW-1:0] qline;
    logic [PW-1:0] qcol;
    while (stream_words < goal) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(8'($urandom), 1'($urandom), 1'b0, 1'($urandom), PW'($urandom),
                  PW'($urandom));
      end else begin
        if (pick < 9) begin
          // opened and dropped: the next first word restarts
          for (int i = $urandom_range(0, 4); i >= 0; i--)
            send_word(8'($urandom), 1'($urandom), i == 0 ? 1'b1 : 1'b0, 1'b0,
                      PW'($urandom), PW'($urandom));
        end
        text = make_text(breaks);
        pick = $urandom_range(99);
        if (pick < 85) qline = PW'($urandom_range(0, breaks + 1));
        else if (pick < 95) qline = PW'($urandom_range(0, breaks));
        else qline = PW'($urandom);
        qcol = ($urandom_range(9) == 0) ? PW'($urandom) : PW'($urandom_range(0, 13));
        send_text(qline, qcol, text, 1'b1);
      end
    end
  endtask

  initial begin
    text_bytes_t nothing;
    tracker = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: edge positions and every way a position can be missed
    send_text('0, PW'(5), nothing, 1'b0);                            // empty text
    send_text('1, '1, {8'h61, NEWLINE}, 1'b0);                       // missing line
    send_text('0, PW'(1), {8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);       // inside a pair
    send_text('0, PW'(2), {8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);       // just after a pair
    send_text(PW'(1), '0, {8'h61, NEWLINE}, 1'b0);                   // empty final line
    send_text('0, PW'(1), {8'hE2, NEWLINE, 8'h41}, 1'b0);            // character overruns
    send_text('0, PW'(3), {8'h61, 8'h62}, 1'b0);                     // column runs out
    send_word(8'h41, 1'b1, 1'b0, 1'b1, '0, '0);                      // no query open
    send_word(8'h78, 1'b1, 1'b1, 1'b0, '0, PW'(3));                  // dropped by restart
    send_text('0, PW'(1), {8'h79, 8'h7A}, 1'b0);
    drain_answers();

    // random: sender idles lightly while receiver stalls often, then the reverse, then no idling
    stream_words = 0;
    random_queries(RANDOM_WORDS / 3);
    drain_answers();
    send_idle_pct = 67;
    recv_stall_pct = 14;
    random_queries(2 * RANDOM_WORDS / 3);
    drain_answers();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_queries(RANDOM_WORDS);

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.offset_answers.size() == 0) begin
      $display("utf16_position_to_byte_offset: match");
    end else begin
      $display("utf16_position_to_byte_offset: mismatch");
    end
    $finish;
  end

endmodule
